### rtl/base64_stream_encoder_core_macros.svh
// Assertion macros used by the encoder back end (b64enc_back).
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/b64enc_pkg.sv
package b64enc_pkg;

  localparam int unsigned GRP_W = 24;

  localparam logic [7:0] CH_PAD  = 8'h3D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SLSH = 8'h2F;

  typedef struct packed {
    logic [GRP_W-1:0] bits;
    logic [1:0]       pads;
    logic             last;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'h41;
    end else if (v < 6'd52) begin
      c = w + 8'd71;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = CH_PLUS;
    end else begin
      c = CH_SLSH;
    end
    return c;
  endfunction

endpackage

### rtl/b64enc_front.sv
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // is_last_byte
  input  q_stat_t    q_stat,
  output logic       push,
  output grp_t       push_grp
);

  logic [7:0] pend0_r, pend0_nxt;
  logic [7:0] pend1_r, pend1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_eff;
  logic       acc;
  logic       done;

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign cnt_eff   = (cnt_r == 2'd3) ? 2'd2 : cnt_r;
  assign done      = in_tlast || (cnt_eff == 2'd2);
  assign push      = acc && done;

  always_comb begin
    push_grp.last = in_tlast;
    unique case (cnt_eff)
      2'd0: begin
        push_grp.bits = {in_tdata, 16'h0000};
        push_grp.pads = in_tlast ? 2'd2 : 2'd0;
      end
      2'd1: begin
        push_grp.bits = {pend0_r, in_tdata, 8'h00};
        push_grp.pads = in_tlast ? 2'd1 : 2'd0;
      end
      default: begin
        push_grp.bits = {pend0_r, pend1_r, in_tdata};
        push_grp.pads = 2'd0;
      end
    endcase
  end

  always_comb begin
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    cnt_nxt   = cnt_r;
    if (acc) begin
      if (done) begin
        cnt_nxt = 2'd0;
      end else begin
        if (cnt_eff == 2'd0) begin
          pend0_nxt = in_tdata;
        end else begin
          pend1_nxt = in_tdata;
        end
        cnt_nxt = cnt_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend0_r <= pend0_nxt;
    pend1_r <= pend1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/b64enc_queue.sv
module b64enc_queue
  import b64enc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  grp_t    push_grp,
  input  logic    pop,
  output grp_t    head,
  output q_stat_t q_stat
);

  grp_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head         = slot_r[rp_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_grp;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/b64enc_back.sv
`include "base64_stream_encoder_core_macros.svh"

module b64enc_back
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  grp_t       head,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // is_last_char
);

  grp_t       cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] od_r, od_nxt;
  logic       ol_r, ol_nxt;
  logic       load;
  logic       fin;
  logic [5:0] sext;
  logic       pad_hit;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  assign load = busy_r && (!ov_r || out_tready);
  assign fin  = load && (idx_r == 2'd3);
  assign pop  = !q_stat.empty && (!busy_r || fin);

  always_comb begin
    unique case (idx_r)
      2'd0:    sext = cur_r.bits[23:18];
      2'd1:    sext = cur_r.bits[17:12];
      2'd2:    sext = cur_r.bits[11:6];
      default: sext = cur_r.bits[5:0];
    endcase
    pad_hit = ((cur_r.pads == 2'd2) && idx_r[1]) ||
              ((cur_r.pads == 2'd1) && (idx_r == 2'd3));
  end

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt  = 1'b1;
      od_nxt  = pad_hit ? CH_PAD : b64_char(sext);
      ol_nxt  = cur_r.last && (idx_r == 2'd3);
      idx_nxt = idx_r + 2'd1;
      if (fin) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      cur_nxt  = head;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    od_r  <= od_nxt;
    ol_r  <= ol_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  `B64_ASSERT_IMP(a_pop_idle, clk, rst_n, pop, !busy_r || fin, "group taken while busy")
  `B64_ASSERT_NXT(a_last_flag, clk, rst_n, fin && cur_r.last, out_tvalid && out_tlast, "last char not flagged")
  `B64_ASSERT_IMP(a_fell_busy, clk, rst_n, $fell(busy_r), $past(idx_r) == 2'd3, "group ended early")
  `B64_ASSERT_IMP(a_pad_tail, clk, rst_n, load && pad_hit, cur_r.last, "pad in mid-message group")

endmodule

### rtl/base64_stream_encoder_core.sv
// Base64 stream encoder (standard alphabet, '=' padding).
// Input channel in_*: one raw byte per word in in_tdata[7:0]; in_tlast marks
//   the final byte of a message. A message must hold at least one byte.
// Output channel out_*: one ASCII character per word in out_tdata[7:0];
//   out_tlast marks the final character of the encoded message.
// Every third byte, and every final byte, closes a group that yields four
//   characters; a short final group is padded with one or two '='.
// The byte that closes a group is written into the group queue; the
//   serializer then loads the group and registers its first character.
// Throughput: the character serializer emits one word per cycle while
//   out_tready is high, four words per group; the input takes one
//   byte per cycle in bursts while the two-group queue has room.
// in_tready drops only while the group queue is full.
// A stall on out_tready holds the output register and backs up the queue,
//   then the input; nothing is dropped.
// Reset (rst_n low, synchronous) empties the queue and the serializer and
//   discards any partially collected group.
module base64_stream_encoder_core
  import b64enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // is_last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // is_last_char
);

  q_stat_t q_stat;
  logic    push;
  grp_t    push_grp;
  logic    pop;
  grp_t    head;

  b64enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_grp  (push_grp)
  );

  b64enc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/base64_stream_encoder_core_test.sv
module base64_stream_encoder_core_test;
  import b64enc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 275;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_byte
  logic       in_tlast   = 1'b0;   // is_last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_char
  logic       out_tlast;           // is_last_char

  enc_char_t  exp_chars[$];
  logic [7:0] grp_bytes[2];
  int         grp_count   = 0;
  int         errors      = 0;
  int         cycle_count = 0;
  int         rx_hold     = 0;
  bit         rx_steady   = 1'b0;
  bit         tx_steady   = 1'b0;

  base64_stream_encoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (s < 6'd26) begin
      return 8'h41 + v;
    end else if (s < 6'd52) begin
      return 8'h61 + (v - 8'd26);
    end else if (s < 6'd62) begin
      return 8'h30 + (v - 8'd52);
    end else if (s == 6'd62) begin
      return CH_PLUS;
    end else begin
      return CH_SLSH;
    end
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [23:0] grp;
    int          pads;
    enc_char_t   c;
    if (!fin && grp_count < 2) begin
      grp_bytes[grp_count] = b;
      grp_count++;
    end else begin
      case (grp_count)
        0:       grp = {b, 16'h0000};
        1:       grp = {grp_bytes[0], b, 8'h00};
        default: grp = {grp_bytes[0], grp_bytes[1], b};
      endcase
      pads = !fin ? 0 : (grp_count == 0) ? 2 : (grp_count == 1) ? 1 : 0;
      for (int k = 0; k < 4; k++) begin
        c.ch   = (k >= 4 - pads) ? CH_PAD : sextet_to_ascii(grp[23-6*k -: 6]);
        c.last = fin && (k == 3);
        exp_chars = {exp_chars, c};
      end
      grp_bytes[0] = 8'h00;
      grp_bytes[1] = 8'h00;
      grp_count    = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    encode_byte(b, fin);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s at cycle %0d: got %h, expected %h",
             field, cycle_count, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_tready <= 1'b1;
          rx_hold = $urandom_range(0, 7);
        end
        6, 7, 8: begin
          out_tready <= 1'b0;
          rx_hold = $urandom_range(0, 2);
        end
        default: begin
          out_tready <= 1'b0;
          rx_hold = $urandom_range(9, 39);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_chars.size() == 0) begin
        report_mismatch("out_char (no word expected)", out_tdata, 8'hxx);
      end else begin
        want = exp_chars.pop_front();
        if (out_tdata !== want.ch) report_mismatch("out_char", out_tdata, want.ch);
        if (out_tlast !== want.last) begin
          report_mismatch("is_last_char", {7'd0, out_tlast}, {7'd0, want.last});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, exp_chars.size());
      $display("base64_stream_encoder_core_test: FAIL");
      $finish;
    end
  end

  // one, two and three byte messages at the byte extremes
  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // groups mapping onto '+' and '/', then a two-byte tail
  task automatic test_alphabet_edges();
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
  endtask

  // full group without end flag, then a single final byte
  task automatic test_group_then_last();
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // sender holds off until the output side is empty
  task automatic test_drain_pause();
    send_message(5);
    wait_drained();
    send_message(3);
    wait_drained();
    send_message(1);
  endtask

  // both sides always active: fills the group queue
  task automatic test_back_to_back();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_message(13);
    send_message(11);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 9);
      else if (r < 92) len = $urandom_range(10, 30);
      else len = $urandom_range(31, 60);
      send_message(len);
      sent += len;
    end
  endtask

  initial begin
    grp_bytes[0] = 8'h00;
    grp_bytes[1] = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_messages();
    test_alphabet_edges();
    test_group_then_last();
    test_drain_pause();
    test_back_to_back();
    test_random_messages();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("base64_stream_encoder_core_test: PASS");
    end else begin
      $display("base64_stream_encoder_core_test: FAIL");
    end
    $finish;
  end

endmodule
